// File: rtl/md5_hash_engine_assert.svh
// Assertion macros shared by the MD5 engine modules.
// No dependencies; included inside module bodies.
`ifndef MD5_HASH_ENGINE_ASSERT_SVH
`define MD5_HASH_ENGINE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define MD5_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define MD5_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// File: rtl/md5_pkg.sv
// Package for the MD5 engine: operation codes, states, round tables, commands.
// No dependencies.
`timescale 1ns / 1ps
package md5_pkg;
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_DIGEST = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUNDS, ST_FOLD, ST_PAD_NEXT, ST_OUT
  } md5_state_t;

  // Command bits from the controller to the datapath.
  typedef struct packed {
    logic       clear;      // return to initial state
    logic       append;     // write one byte into the buffer
    logic       start;      // load working words from chaining or digest copy
    logic       from_copy;  // start from digest copy instead of chaining words
    logic       pad_mode;   // message words come through the pad mux
    logic       second;     // second padded block
    logic       round;      // run one round
    logic       fold_chain; // add working words into chaining words
    logic       fold_copy;  // add working words into digest copy
    logic       copy_init;  // digest copy takes the chaining words
  } md5_cmd_t;

  typedef struct packed {
    logic       last_round;
    logic       block_full;  // append completes a block
    logic       two_blocks;
  } md5_stat_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
          32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
          32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
          32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
          32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
          32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
          32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
          32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
          32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
          32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
          32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
          32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
          32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
          32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
          32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
          32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[i];
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s [16];
    s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return s[{i[5:4], i[1:0]}];
  endfunction

  // Message word index used by round i.
  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction
endpackage

// File: rtl/md5_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; the payload type is a parameter.
`timescale 1ns / 1ps
interface md5_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/md5_ctrl.sv
// Controller state machine of the MD5 engine.
// Depends on md5_pkg and md5_hash_engine_assert.svh.
`timescale 1ns / 1ps
module md5_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  output logic             out_valid,
  input  logic             out_ready,
  input  md5_pkg::md5_stat_t stat,
  output md5_pkg::md5_cmd_t  cmd
);
  import md5_pkg::*;
  `include "md5_hash_engine_assert.svh"

  md5_state_t state, state_next;
  logic       digest_job, digest_job_next;  // current compression is for a digest
  logic       second, second_next;
  logic       acc;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      digest_job <= 1'b0;
      second <= 1'b0;
    end else begin
      state <= state_next;
      digest_job <= digest_job_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next = state;
    digest_job_next = digest_job;
    second_next = second;
    case (state)
      ST_IDLE: begin
        if (acc && in_op == OP_APPEND && stat.block_full) begin
          state_next = ST_ROUNDS;
          digest_job_next = 1'b0;
          second_next = 1'b0;
        end else if (acc && in_op == OP_DIGEST) begin
          state_next = ST_ROUNDS;
          digest_job_next = 1'b1;
          second_next = 1'b0;
        end
      end
      ST_ROUNDS: if (stat.last_round) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!digest_job) state_next = ST_IDLE;
        else if (stat.two_blocks && !second) state_next = ST_PAD_NEXT;
        else state_next = ST_OUT;
      end
      ST_PAD_NEXT: begin
        state_next = ST_ROUNDS;
        second_next = 1'b1;
      end
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    cmd.second = second;
    cmd.pad_mode = digest_job;
    case (state)
      ST_IDLE: begin
        cmd.clear = acc && in_op == OP_CLEAR;
        cmd.append = acc && in_op == OP_APPEND;
        cmd.start = acc && ((in_op == OP_APPEND && stat.block_full) || in_op == OP_DIGEST);
        cmd.copy_init = acc && in_op == OP_DIGEST;
        cmd.second = 1'b0;
        cmd.pad_mode = acc && in_op == OP_DIGEST;
      end
      ST_ROUNDS: cmd.round = 1'b1;
      ST_FOLD: begin
        cmd.fold_chain = !digest_job;
        cmd.fold_copy = digest_job;
      end
      ST_PAD_NEXT: begin
        cmd.start = 1'b1;
        cmd.from_copy = 1'b1;
        cmd.second = 1'b1;
      end
      default: ;
    endcase
  end

  `MD5_ASSERT_IMPL(a_out_only_digest, clk, rst, out_valid, digest_job)
  `MD5_ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid)
  `MD5_ASSERT_IMPL(a_no_input_busy, clk, rst, state != ST_IDLE, !in_ready)
endmodule

// File: rtl/md5_datapath.sv
// Datapath of the MD5 engine: block buffer, counters, round unit, chaining words.
// Depends on md5_pkg and md5_hash_engine_assert.svh.
`timescale 1ns / 1ps
module md5_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         in_byte,
  input  md5_pkg::md5_cmd_t  cmd,
  output md5_pkg::md5_stat_t stat,
  output logic [63:0]        digest_low,
  output logic [63:0]        digest_high
);
  import md5_pkg::*;
  `include "md5_hash_engine_assert.svh"

  logic [31:0] buffer [16];   // message words, byte 0 of a word in bits 7:0
  logic [5:0]  fill;
  logic [60:0] done_count;
  logic [31:0] chain [4];
  logic [31:0] copy [4];
  logic [31:0] a, b, c, d;
  logic [5:0]  rnd;
  logic [31:0] word;
  logic [3:0]  g;
  logic [63:0] bits;
  logic [31:0] f, sum, rot;
  logic [4:0]  s;
  logic [5:0]  wbase;
  logic [3:0]  g_now;

  // Registered read of the buffer word that the next round needs.
  logic [31:0] rd;

  assign stat.block_full = (fill == 6'd63);
  assign stat.two_blocks = (fill >= 6'd56);
  assign stat.last_round = (rnd == 6'd63);
  assign bits = {done_count + 61'(fill), 3'b000};

  // Padded byte at a position of the current block.
  function automatic logic [7:0] pad_byte(input logic [6:0] pos, input logic [7:0] bufv,
                                          input logic [5:0] fl, input logic [63:0] bl,
                                          input logic [7:0] total);
    logic [7:0] r;
    logic [2:0] idx;
    r = 8'h00;
    idx = 3'({1'b0, pos} - (total - 8'd8));
    if (pos < {1'b0, fl}) r = bufv;
    else if (pos == {1'b0, fl}) r = 8'h80;
    else if ({1'b0, pos} >= total - 8'd8) r = bl[8 * idx +: 8];
    return r;
  endfunction

  assign g = (cmd.start) ? 4'd0 : round_g(rnd + 6'd1);

  // Round counter steps through 0..63; word for round rnd is prefetched.
  always_ff @(posedge clk) begin
    rd <= buffer[g];
  end

  always_ff @(posedge clk) g_now <= g;
  assign wbase = {g_now, 2'b00};

  always_comb begin
    logic [7:0] total;
    logic [6:0] base;
    total = stat.two_blocks ? 8'd128 : 8'd64;
    base = {cmd.second, wbase};
    for (int j = 0; j < 4; j++) begin
      word[8*j +: 8] = cmd.pad_mode ?
        pad_byte(base + 7'(j), rd[8*j +: 8], fill, bits, total) : rd[8*j +: 8];
    end
  end

  assign s = round_s(rnd);
  always_comb begin
    case (rnd[5:4])
      2'd0: f = d ^ (b & (c ^ d));
      2'd1: f = c ^ (d & (b ^ c));
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum = a + f + word + round_k(rnd);
    rot = (s == 5'd0) ? sum : ((sum << s) | (sum >> (6'd32 - {1'b0, s})));
  end

  always_ff @(posedge clk) begin
    if (cmd.append) buffer[fill[5:2]][8*fill[1:0] +: 8] <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill <= '0;
      done_count <= '0;
      chain[0] <= IV0; chain[1] <= IV1; chain[2] <= IV2; chain[3] <= IV3;
      rnd <= '0;
    end else begin
      if (cmd.append) begin
        fill <= fill + 6'd1;
        if (stat.block_full) done_count <= done_count + 61'd64;
      end
      if (cmd.start) rnd <= '0;
      else if (cmd.round) rnd <= rnd + 6'd1;
      if (cmd.fold_chain) begin
        chain[0] <= chain[0] + a; chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c; chain[3] <= chain[3] + d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_init) for (int j = 0; j < 4; j++) copy[j] <= chain[j];
    if (cmd.fold_copy) begin
      copy[0] <= copy[0] + a; copy[1] <= copy[1] + b;
      copy[2] <= copy[2] + c; copy[3] <= copy[3] + d;
    end
    if (cmd.start) begin
      if (cmd.from_copy) begin
        a <= copy[0]; b <= copy[1]; c <= copy[2]; d <= copy[3];
      end else begin
        a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3];
      end
    end else if (cmd.round) begin
      a <= d; d <= c; c <= b; b <= b + rot;
    end
  end

  assign digest_low = {copy[1], copy[0]};
  assign digest_high = {copy[3], copy[2]};

  `MD5_ASSERT_NEXT(a_block_wraps, clk, rst, cmd.append && stat.block_full, fill == 6'd0)
  `MD5_ASSERT_IMPL(a_no_mixed, clk, rst, cmd.round, !cmd.append && !cmd.start)
  `MD5_ASSERT_NEXT(a_round_steps, clk, rst, cmd.round && !stat.last_round,
                   rnd == $past(rnd) + 6'd1)
endmodule

// File: rtl/md5_hash_engine.sv
// Top level of the streaming MD5 engine; joins controller and datapath.
// Depends on md5_pkg, md5_if, md5_ctrl and md5_datapath.
`timescale 1ns / 1ps
// Streaming MD5 (RFC 1321). Each input item appends a byte, asks for the
// digest, or clears the engine. Other appends do not stall the input, but
// the 64th byte of a block starts the compression: the working words load as
// the byte is taken, one round per cycle then runs through the rounds and the
// fold state adds the result into the chaining words; the input stalls until
// then. A digest request compresses one padded block (buffer fill below 56)
// or two (the pad state reloads the working words from the digest copy
// between the blocks), then holds the digest item until it is taken; no new
// input item is taken meanwhile. The running state is left untouched by a
// digest request. There is no clearing pass; the block buffer needs none
// since only bytes already written are read.
module md5_hash_engine (
  input logic clk,
  input logic rst,
  md5_if.sink   in_ch,
  md5_if.source out_ch
);
  import md5_pkg::*;

  md5_cmd_t  cmd;
  md5_stat_t stat;

  md5_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_op    (in_ch.payload.operation),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  md5_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_ch.payload.data_byte),
    .cmd        (cmd),
    .stat       (stat),
    .digest_low (out_ch.payload.digest_low),
    .digest_high(out_ch.payload.digest_high)
  );
endmodule

// File: bench/md5_tb_pkg.sv
// Item types for the MD5 engine bench: request item and digest item.
// Depends on md5_pkg for the operation code width.
`timescale 1ns / 1ps
package md5_tb_pkg;
  import md5_pkg::*;

  // Code 3 is not used by the engine and must be ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } md5_req_t;

  typedef struct packed {
    logic [63:0] digest_low;
    logic [63:0] digest_high;
  } md5_digest_t;
endpackage

// File: bench/md5_hash_checker.sv
// Watches both channels of the MD5 engine, predicts digests and compares.
// Depends on md5_pkg, md5_tb_pkg and md5_if.
`timescale 1ns / 1ps
module md5_hash_checker (
  input  logic clk,
  input  logic rst,
  md5_if       in_mon,
  md5_if       out_mon,
  output int   fail_count
);
  import md5_pkg::*;
  import md5_tb_pkg::*;

  logic [31:0] sine_k [64];
  logic [4:0]  shift_tab [16] = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
                                  5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};

  logic [31:0] chain [4];
  logic [7:0]  msg_buf [64];
  logic [5:0]  fill;
  logic [60:0] done_bytes;
  md5_digest_t digest_q [$];
  int          fails = 0;

  assign fail_count = fails;

  initial begin
    real r;
    for (int i = 0; i < 64; i++) begin
      r = $sin(i + 1);
      if (r < 0.0) r = -r;
      sine_k[i] = 32'(longint'($floor(r * 4294967296.0)));
    end
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    return (x << s) | (x >> (6'd32 - s));
  endfunction

  // One 64-step compression of a block, added into h.
  task automatic compress_block(inout logic [31:0] h [4], input logic [511:0] blk);
    logic [31:0] a, b, c, d, f, t;
    int g;
    a = h[0]; b = h[1]; c = h[2]; d = h[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = d ^ (b & (c ^ d)); g = i; end
        1: begin f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = d; d = c; c = b;
      b = b + rotl(a + f + blk[32*g +: 32] + sine_k[i], shift_tab[(i / 16) * 4 + i % 4]);
      a = t;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
  endtask

  task automatic clear_state();
    chain = '{IV0, IV1, IV2, IV3};
    fill = '0;
    done_bytes = '0;
  endtask

  task automatic predict_digest(output md5_digest_t res);
    logic [1023:0] pad;
    logic [31:0] h [4];
    logic [63:0] bit_len;
    int total;
    pad = '0;
    total = (fill < 56) ? 64 : 128;
    bit_len = {done_bytes + 61'(fill), 3'b000};
    for (int i = 0; i < fill; i++) pad[8*i +: 8] = msg_buf[i];
    pad[8*fill +: 8] = 8'h80;
    pad[8*(total - 8) +: 64] = bit_len;
    h = chain;
    compress_block(h, pad[511:0]);
    if (total == 128) compress_block(h, pad[1023:512]);
    res.digest_low = {h[1], h[0]};
    res.digest_high = {h[3], h[2]};
  endtask

  initial begin
    clear_state();
  end

  always @(posedge clk) begin
    md5_req_t req;
    md5_digest_t want, got;
    logic [511:0] blk;
    if (!rst) begin
      if (in_mon.valid && in_mon.ready) begin
        req = in_mon.payload;
        case (req.operation)
          OP_APPEND: begin
            msg_buf[fill] = req.data_byte;
            if (fill == 6'd63) begin
              for (int i = 0; i < 64; i++) blk[8*i +: 8] = msg_buf[i];
              compress_block(chain, blk);
              done_bytes = done_bytes + 61'd64;
            end
            fill = fill + 6'd1;
          end
          OP_DIGEST: begin
            predict_digest(want);
            digest_q.push_back(want);
          end
          OP_CLEAR: clear_state();
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        if (digest_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("Unexpected digest item %h", got);
        end else begin
          want = digest_q.pop_front();
          if (got.digest_low !== want.digest_low || got.digest_high !== want.digest_high) begin
            fails++;
            if (fails <= 10)
              $display("Digest mismatch: expected %h_%h, got %h_%h", want.digest_high,
                       want.digest_low, got.digest_high, got.digest_low);
          end
        end
      end
    end
  end

  final begin
    if (digest_q.size() != 0) $display("%0d digests never arrived", digest_q.size());
  end

  // The top asks for the leftover count before its verdict.
  function automatic int pending();
    return digest_q.size();
  endfunction
endmodule

// File: bench/md5_hash_engine_tb.sv
// Top of the MD5 engine bench: clock, reset, request stimulus, digest sink, verdict.
// Depends on md5_pkg, md5_tb_pkg, md5_if, md5_hash_checker and md5_hash_engine.
`timescale 1ns / 1ps
module md5_hash_engine_tb;
  import md5_pkg::*;
  import md5_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   digests_sent = 0;
  int   digests_taken = 0;
  int   items_sent = 0;
  // Set by the stimulus to ask the digest sink for one long stall.
  logic long_hold_req = 1'b0;

  md5_if #(.payload_t(md5_req_t))    in_ch ();
  md5_if #(.payload_t(md5_digest_t)) out_ch ();

  always #1 clk = ~clk;

  md5_hash_engine dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  md5_hash_checker checker_i (
    .clk(clk),
    .rst(rst),
    .in_mon(in_ch),
    .out_mon(out_ch),
    .fail_count(fail_count)
  );

  // Offer one item after a random gap and hold it until the engine takes it.
  // Valid stays high across back-to-back items so it is never dropped and
  // raised within one step.
  task automatic send_item(input logic [1:0] op, input logic [7:0] data);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{operation: op, data_byte: data};
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (op == OP_DIGEST) digests_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(OP_APPEND, 8'($urandom));
  endtask

  // Holds stimulus until every digest asked for has been taken.
  task automatic drain_digests();
    in_ch.valid <= 1'b0;
    while (digests_taken != digests_sent) @(posedge clk);
  endtask

  // Digest sink: random ready gaps, plus one long stall on request.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (long_hold_req) begin
        gap = 400;
        long_hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      digests_taken++;
    end
  end

  initial begin
    int kind;
    int len;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty message, short message, the padding boundary
    // around 56 bytes, a full block, the unused code and a clear.
    send_item(OP_DIGEST, 8'h00);
    send_item(OP_APPEND, 8'h00);
    send_item(OP_APPEND, 8'hff);
    send_item(OP_DIGEST, 8'hff);
    send_item(OP_UNUSED, 8'hff);
    send_item(OP_DIGEST, 8'h00);
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_DIGEST, 8'h00);
    drain_digests();
    send_message(55);
    send_item(OP_DIGEST, 8'h00);
    send_item(OP_APPEND, 8'h61);
    send_item(OP_DIGEST, 8'h00);
    send_message(7);
    send_item(OP_DIGEST, 8'h00);
    send_item(OP_APPEND, 8'h80);
    send_item(OP_DIGEST, 8'h00);
    send_item(OP_CLEAR, 8'hff);
    drain_digests();

    // Long sink stall while digest requests keep arriving, so the engine
    // backs up and stalls its input.
    long_hold_req = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_message(3);
      send_item(OP_DIGEST, 8'h00);
    end
    drain_digests();

    // Random part: mostly messages of random length followed by a digest,
    // with clears and the unused code as noise.
    while (items_sent < 850) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 140) : $urandom_range(0, 20);
        send_message(len);
        send_item(OP_DIGEST, 8'($urandom));
      end else if (kind < 16) begin
        send_item(OP_CLEAR, 8'($urandom));
      end else if (kind < 18) begin
        send_item(OP_UNUSED, 8'($urandom));
      end else begin
        drain_digests();
      end
    end

    drain_digests();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && checker_i.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
